FILE: rtl/spi_mon_pkg.sv
`timescale 1ns / 1ps

package spi_mon_pkg;

	localparam int unsigned BitsPerByte = 8;
	localparam int unsigned BitCntBits  = $clog2(BitsPerByte);

	typedef enum logic [1:0] {
		SPI_MODE0 = 2'd0,
		SPI_MODE1 = 2'd1,
		SPI_MODE2 = 2'd2,
		SPI_MODE3 = 2'd3
	} spi_mode_t;

	typedef struct packed {
		logic [BitsPerByte-1:0] mosi_byte;
		logic [BitsPerByte-1:0] miso_byte;
		logic                   in_transaction;
	} spi_bytes_t;

	function automatic logic capture_on_rise(input spi_mode_t mode);
		logic rise;
		case (mode)
			SPI_MODE0, SPI_MODE3: rise = 1'b1;
			default:              rise = 1'b0;
		endcase
		return rise;
	endfunction

endpackage

FILE: rtl/spi_mon_core.sv
`timescale 1ns / 1ps

module spi_mon_core import spi_mon_pkg::*; #(
	parameter int unsigned BYTE_INDEX_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  spi_mode_t                  mode,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       sclk_level,
	input  logic                       cs_n_level,
	input  logic                       mosi_level,
	input  logic                       miso_level,
	input  logic                       res_room,
	output logic                       res_push,
	output spi_bytes_t                 res_bytes,
	output logic [BYTE_INDEX_BITS-1:0] res_index
);

	localparam logic [BYTE_INDEX_BITS-1:0] IndexMax = '1;
	localparam logic [BitCntBits-1:0]      BitLast  = BitCntBits'(BitsPerByte - 1);

	logic valid_s1;
	logic sclk_s1;
	logic cs_n_s1;
	logic mosi_s1;
	logic miso_s1;

	logic                       prev_sclk_q;
	logic                       seen_q;
	logic                       prev_cs_q;
	logic [BitsPerByte-1:0]     mosi_shift_q;
	logic [BitsPerByte-1:0]     miso_shift_q;
	logic [BitCntBits-1:0]      bit_cnt_q;
	logic [BYTE_INDEX_BITS-1:0] byte_cnt_q;

	logic                       cs_active;
	logic                       cs_assert;
	logic [BitCntBits-1:0]      bit_base;
	logic [BYTE_INDEX_BITS-1:0] byte_base;
	logic                       rising;
	logic                       falling;
	logic                       capture;
	logic                       done;
	logic [BitsPerByte-1:0]     mosi_next;
	logic [BitsPerByte-1:0]     miso_next;
	logic [BYTE_INDEX_BITS-1:0] byte_next;
	logic                       advance;

	always_comb begin
		cs_active = ~cs_n_s1;
		cs_assert = cs_active & ~prev_cs_q;
		bit_base  = cs_assert ? '0 : bit_cnt_q;
		byte_base = cs_assert ? '0 : byte_cnt_q;
		rising    = seen_q & ~prev_sclk_q & sclk_s1;
		falling   = seen_q & prev_sclk_q & ~sclk_s1;
		capture   = capture_on_rise(mode) ? rising : falling;
		done      = capture && (bit_base == BitLast);
		mosi_next = {mosi_shift_q[BitsPerByte-2:0], mosi_s1};
		miso_next = {miso_shift_q[BitsPerByte-2:0], miso_s1};
		byte_next = (done && (byte_base != IndexMax)) ? byte_base + 1'b1 : byte_base;
		advance   = valid_s1 & (~done | res_room);
	end

	assign in_stall  = valid_s1 & ~advance;
	assign res_push  = advance & done;
	assign res_bytes = '{mosi_byte: mosi_next, miso_byte: miso_next, in_transaction: cs_active};
	assign res_index = byte_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sclk_s1 <= sclk_level;
			cs_n_s1 <= cs_n_level;
			mosi_s1 <= mosi_level;
			miso_s1 <= miso_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sclk_q  <= 1'b0;
			seen_q       <= 1'b0;
			prev_cs_q    <= 1'b0;
			mosi_shift_q <= '0;
			miso_shift_q <= '0;
			bit_cnt_q    <= '0;
			byte_cnt_q   <= '0;
		end else if (advance) begin
			prev_sclk_q <= sclk_s1;
			seen_q      <= 1'b1;
			prev_cs_q   <= cs_active;
			byte_cnt_q  <= byte_next;
			if (capture) begin
				mosi_shift_q <= mosi_next;
				miso_shift_q <= miso_next;
				bit_cnt_q    <= bit_base + 1'b1;
			end else begin
				bit_cnt_q <= bit_base;
			end
		end
	end

	// A result always carries a 1-based byte index.
	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> res_index != '0)
		else $error("result pushed with a zero byte index");

	// Chip select assertion restarts the bit count; at most one bit lands in the same item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cs_assert) |=> (bit_cnt_q == '0 || bit_cnt_q == BitCntBits'(1)))
		else $error("bit counter not restarted on chip select assertion");

	// The byte counter only moves by one step unless chip select is asserted.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !cs_assert) |=>
		(byte_cnt_q == $past(byte_cnt_q) || byte_cnt_q == $past(byte_cnt_q) + 1'b1))
		else $error("byte counter jumped");

endmodule

FILE: rtl/spi_mon_outq.sv
`timescale 1ns / 1ps

module spi_mon_outq import spi_mon_pkg::*; #(
	parameter int unsigned BYTE_INDEX_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  spi_bytes_t                 push_bytes,
	input  logic [BYTE_INDEX_BITS-1:0] push_index,
	output logic                       room,
	output logic                       out_valid,
	input  logic                       out_stall,
	output spi_bytes_t                 out_bytes,
	output logic [BYTE_INDEX_BITS-1:0] out_index
);

	spi_bytes_t                 bytes_q [2];
	logic [BYTE_INDEX_BITS-1:0] index_q [2];
	logic                       wr_ptr_q;
	logic                       rd_ptr_q;
	logic [1:0]                 count_q;
	logic                       pop;

	assign out_valid = count_q != 2'd0;
	assign room      = count_q != 2'd2;
	assign pop       = out_valid & ~out_stall;
	assign out_bytes = bytes_q[rd_ptr_q];
	assign out_index = index_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			bytes_q[wr_ptr_q] <= push_bytes;
			index_q[wr_ptr_q] <= push_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Nothing is written into a full buffer.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> count_q != 2'd2)
		else $error("push into full result buffer");

endmodule

FILE: rtl/spi_bus_byte_monitor_top.sv
`timescale 1ns / 1ps

// Passive SPI bus byte monitor.
// The input channel takes one sample of the SCLK, chip select, MOSI and MISO pins per item,
// qualified by in_valid and held off by in_stall. The output channel presents one item per
// completed byte: the MOSI and MISO bytes, whether chip select was active, and the 1-based
// byte index since chip select was asserted, qualified by out_valid and held by out_stall.
// Samples that complete no byte produce no output item.
// The SPI mode is written through cfg_wr_en and cfg_wr_data; the user must write it only while no
// sample is in flight, as the block itself does not enforce this. An accepted item is registered,
// processed in a single pass and lands in a two-entry result buffer, from which it is taken.
// One sample is accepted every cycle as long as the result buffer has room.
// When the receiver stalls, the buffer fills; in_stall rises only when the buffer is full
// and the pending sample would complete a byte.
// Reset clears the mode to 0, the edge detector, shift registers, counters and the buffer.
// The first sample after reset only loads the edge detector.
module spi_bus_byte_monitor_top import spi_mon_pkg::*; #(
	parameter int unsigned BYTE_INDEX_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [1:0]                 cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       sclk_level,
	input  logic                       cs_n_level,
	input  logic                       mosi_level,
	input  logic                       miso_level,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [BitsPerByte-1:0]     mosi_byte,
	output logic [BitsPerByte-1:0]     miso_byte,
	output logic                       in_transaction,
	output logic [BYTE_INDEX_BITS-1:0] byte_index
);

	spi_mode_t                  mode_q;
	logic                       res_room;
	logic                       res_push;
	spi_bytes_t                 res_bytes;
	logic [BYTE_INDEX_BITS-1:0] res_index;
	spi_bytes_t                 out_bytes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= SPI_MODE0;
		end else if (cfg_wr_en) begin
			mode_q <= spi_mode_t'(cfg_wr_data);
		end
	end

	spi_mon_core #(
		.BYTE_INDEX_BITS(BYTE_INDEX_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sclk_level (sclk_level),
		.cs_n_level (cs_n_level),
		.mosi_level (mosi_level),
		.miso_level (miso_level),
		.res_room   (res_room),
		.res_push   (res_push),
		.res_bytes  (res_bytes),
		.res_index  (res_index)
	);

	spi_mon_outq #(
		.BYTE_INDEX_BITS(BYTE_INDEX_BITS)
	) u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_push),
		.push_bytes (res_bytes),
		.push_index (res_index),
		.room       (res_room),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_bytes  (out_bytes),
		.out_index  (byte_index)
	);

	assign mosi_byte      = out_bytes.mosi_byte;
	assign miso_byte      = out_bytes.miso_byte;
	assign in_transaction = out_bytes.in_transaction;

endmodule
